// ===== hw/rtl/bls_pkg.sv =====
// Shared constants and types for the Bresenham line stepper.
`timescale 1ns / 1ps

package bls_pkg;

   // Coordinate width default and the fixed width of the screen size registers.
   localparam int COORD_BITS_DEF = 16;
   localparam int DIM_W          = 15;

   // Screen size after reset.
   localparam logic [DIM_W-1:0] HRES_RST = 15'd1920;
   localparam logic [DIM_W-1:0] VRES_RST = 15'd1080;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_HRES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_VRES = 1'b1;

   // Item functions.
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   // Control of the setup stage as seen by the step stage.
   typedef struct packed {
      logic valid;
      logic start;
   } stage_ctl_type;

endpackage

// ===== hw/rtl/bls_req_if.sv =====
// Request, response and configuration channel interfaces.
`timescale 1ns / 1ps

interface bls_req_if #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;

   modport source (output valid, func, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, func, start_x, start_y, end_x, end_y, output ready);
   modport mon    (input valid, ready, func, start_x, start_y, end_x, end_y);
endinterface

interface bls_rsp_if #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] pixel_x;
   logic signed [COORD_BITS-1:0] pixel_y;
   logic                         plotted;
   logic                         last;

   modport source (output valid, pixel_x, pixel_y, plotted, last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, plotted, last, output ready);
   modport mon    (input valid, ready, pixel_x, pixel_y, plotted, last);
endinterface

interface bls_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [bls_pkg::CSR_IDX_W-1:0]          index;
   logic [bls_pkg::DIM_W-1:0]              data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
   modport mon    (input valid, ready, index, data);
endinterface

// ===== hw/rtl/bls_setup.sv =====
// Input register stage: captures an item and forms the line setup terms.
`timescale 1ns / 1ps

module bls_setup #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic                          advance,
   input  logic                          func,
   input  logic signed [COORD_BITS-1:0]  start_x,
   input  logic signed [COORD_BITS-1:0]  start_y,
   input  logic signed [COORD_BITS-1:0]  end_x,
   input  logic signed [COORD_BITS-1:0]  end_y,
   output bls_pkg::stage_ctl_type        ctl,
   output logic signed [COORD_BITS-1:0]  cur_x,
   output logic signed [COORD_BITS-1:0]  cur_y,
   output logic signed [COORD_BITS-1:0]  target_x,
   output logic signed [COORD_BITS-1:0]  target_y,
   output logic        [COORD_BITS:0]    delta_x,
   output logic signed [COORD_BITS+1:0]  neg_delta_y,
   output logic                          step_x_neg,
   output logic                          step_y_neg,
   output logic signed [COORD_BITS+2:0]  err_acc
);

   localparam int DW = COORD_BITS + 1;
   localparam int NW = COORD_BITS + 2;
   localparam int EW = COORD_BITS + 3;

   logic signed [DW-1:0] diff_x, rev_x, diff_y, rev_y;
   logic        [DW-1:0] abs_x;
   logic signed [DW-1:0] neg_y;
   logic signed [NW-1:0] ndy_in;
   logic signed [EW-1:0] err_in;

   logic valid_ff, valid_in, start_ff;
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_y_ff, target_x_ff, target_y_ff;
   logic        [DW-1:0]         delta_x_ff;
   logic signed [NW-1:0]         neg_delta_y_ff;
   logic                         step_x_neg_ff, step_y_neg_ff;
   logic signed [EW-1:0]         err_acc_ff;

   // Both differences in each direction side by side, so |d| is a select.
   always_comb begin
      diff_x = $signed({end_x[COORD_BITS-1], end_x}) - $signed({start_x[COORD_BITS-1], start_x});
      rev_x  = $signed({start_x[COORD_BITS-1], start_x}) - $signed({end_x[COORD_BITS-1], end_x});
      diff_y = $signed({end_y[COORD_BITS-1], end_y}) - $signed({start_y[COORD_BITS-1], start_y});
      rev_y  = $signed({start_y[COORD_BITS-1], start_y}) - $signed({end_y[COORD_BITS-1], end_y});
      abs_x  = diff_x[DW-1] ? rev_x : diff_x;
      neg_y  = diff_y[DW-1] ? diff_y : rev_y;
      ndy_in = $signed({neg_y[DW-1], neg_y});
      err_in = $signed({2'b00, abs_x}) + $signed({ndy_in[NW-1], ndy_in});
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         start_ff       <= (func == bls_pkg::FUNC_START);
         cur_x_ff       <= start_x;
         cur_y_ff       <= start_y;
         target_x_ff    <= end_x;
         target_y_ff    <= end_y;
         delta_x_ff     <= abs_x;
         neg_delta_y_ff <= ndy_in;
         step_x_neg_ff  <= !(start_x < end_x);
         step_y_neg_ff  <= !(start_y < end_y);
         err_acc_ff     <= err_in;
      end
   end

   assign ctl.valid   = valid_ff;
   assign ctl.start   = start_ff;
   assign cur_x       = cur_x_ff;
   assign cur_y       = cur_y_ff;
   assign target_x    = target_x_ff;
   assign target_y    = target_y_ff;
   assign delta_x     = delta_x_ff;
   assign neg_delta_y = neg_delta_y_ff;
   assign step_x_neg  = step_x_neg_ff;
   assign step_y_neg  = step_y_neg_ff;
   assign err_acc     = err_acc_ff;

endmodule

// ===== hw/rtl/bls_step.sv =====
// Line state and the clip, plot and advance logic.
`timescale 1ns / 1ps

module bls_step #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  bls_pkg::stage_ctl_type        ctl,
   input  logic signed [COORD_BITS-1:0]  ld_cur_x,
   input  logic signed [COORD_BITS-1:0]  ld_cur_y,
   input  logic signed [COORD_BITS-1:0]  ld_target_x,
   input  logic signed [COORD_BITS-1:0]  ld_target_y,
   input  logic        [COORD_BITS:0]    ld_delta_x,
   input  logic signed [COORD_BITS+1:0]  ld_neg_delta_y,
   input  logic                          ld_step_x_neg,
   input  logic                          ld_step_y_neg,
   input  logic signed [COORD_BITS+2:0]  ld_err_acc,
   input  logic        [bls_pkg::DIM_W-1:0] hres,
   input  logic        [bls_pkg::DIM_W-1:0] vres,
   output logic signed [COORD_BITS-1:0]  pixel_x,
   output logic signed [COORD_BITS-1:0]  pixel_y,
   output logic                          plotted,
   output logic                          last
);

   localparam int DW = COORD_BITS + 1;
   localparam int NW = COORD_BITS + 2;
   localparam int EW = COORD_BITS + 3;
   localparam int TW = COORD_BITS + 4;
   localparam int CW = COORD_BITS + bls_pkg::DIM_W + 1;

   logic signed [COORD_BITS-1:0] cur_x_ff, cur_y_ff, target_x_ff, target_y_ff;
   logic signed [COORD_BITS-1:0] cur_x_in, cur_y_in, target_x_in, target_y_in;
   logic        [DW-1:0]         delta_x_ff, delta_x_in;
   logic signed [NW-1:0]         neg_delta_y_ff, neg_delta_y_in;
   logic                         step_x_neg_ff, step_x_neg_in;
   logic                         step_y_neg_ff, step_y_neg_in;
   logic signed [EW-1:0]         err_acc_ff, err_acc_in;
   logic                         active_ff, active_in;

   logic signed [CW-1:0] cx_ext, cy_ext, w_ext, h_ext;
   logic signed [TW-1:0] e2, ndy_t, dx_t;
   logic                 act, off_screen, at_end, move_x, move_y;

   // Working copy: freshly loaded setup on a start item, stored state otherwise.
   always_comb begin
      if (ctl.start) begin
         cur_x_in       = ld_cur_x;
         cur_y_in       = ld_cur_y;
         target_x_in    = ld_target_x;
         target_y_in    = ld_target_y;
         delta_x_in     = ld_delta_x;
         neg_delta_y_in = ld_neg_delta_y;
         step_x_neg_in  = ld_step_x_neg;
         step_y_neg_in  = ld_step_y_neg;
         err_acc_in     = ld_err_acc;
         act            = 1'b1;
      end else begin
         cur_x_in       = cur_x_ff;
         cur_y_in       = cur_y_ff;
         target_x_in    = target_x_ff;
         target_y_in    = target_y_ff;
         delta_x_in     = delta_x_ff;
         neg_delta_y_in = neg_delta_y_ff;
         step_x_neg_in  = step_x_neg_ff;
         step_y_neg_in  = step_y_neg_ff;
         err_acc_in     = err_acc_ff;
         act            = active_ff;
      end
   end

   always_comb begin
      cx_ext     = $signed({{(bls_pkg::DIM_W+1){cur_x_in[COORD_BITS-1]}}, cur_x_in});
      cy_ext     = $signed({{(bls_pkg::DIM_W+1){cur_y_in[COORD_BITS-1]}}, cur_y_in});
      w_ext      = $signed({{(COORD_BITS+1){1'b0}}, hres});
      h_ext      = $signed({{(COORD_BITS+1){1'b0}}, vres});
      off_screen = (cx_ext >= w_ext) || (cy_ext >= h_ext);
      at_end     = (cur_x_in == target_x_in) && (cur_y_in == target_y_in);
      e2         = $signed({err_acc_in, 1'b0});
      ndy_t      = $signed({{2{neg_delta_y_in[NW-1]}}, neg_delta_y_in});
      dx_t       = $signed({3'b000, delta_x_in});
      move_x     = (e2 >= ndy_t);
      move_y     = (e2 <= dx_t);
   end

   // Result of this step and the state it leaves.
   always_comb begin
      pixel_x   = cur_x_in;
      pixel_y   = cur_y_in;
      plotted   = !cur_x_in[COORD_BITS-1] && !cur_y_in[COORD_BITS-1];
      last      = 1'b0;
      active_in = 1'b0;
      if (!act) begin
         pixel_x = '0;
         pixel_y = '0;
         plotted = 1'b0;
         last    = 1'b1;
      end else if (off_screen) begin
         plotted = 1'b0;
         last    = 1'b1;
      end else if (at_end) begin
         last    = 1'b1;
      end else if (move_x && (cur_x_in == target_x_in)) begin
         last    = 1'b1;
      end else if (move_y && (cur_y_in == target_y_in)) begin
         last    = 1'b1;
      end else begin
         active_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (fire) begin
         active_ff <= active_in;
      end
   end

   // Coordinates and error only matter while the line stays active.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         target_x_ff    <= '0;
         target_y_ff    <= '0;
         delta_x_ff     <= '0;
         neg_delta_y_ff <= '0;
         step_x_neg_ff  <= 1'b0;
         step_y_neg_ff  <= 1'b0;
         err_acc_ff     <= '0;
      end else if (fire) begin
         cur_x_ff       <= move_x ? cur_x_in + {{(COORD_BITS-1){step_x_neg_in}}, 1'b1}
                                  : cur_x_in;
         cur_y_ff       <= move_y ? cur_y_in + {{(COORD_BITS-1){step_y_neg_in}}, 1'b1}
                                  : cur_y_in;
         target_x_ff    <= target_x_in;
         target_y_ff    <= target_y_in;
         delta_x_ff     <= delta_x_in;
         neg_delta_y_ff <= neg_delta_y_in;
         step_x_neg_ff  <= step_x_neg_in;
         step_y_neg_ff  <= step_y_neg_in;
         err_acc_ff     <= err_acc_in
                         + (move_x ? $signed({neg_delta_y_in[NW-1], neg_delta_y_in})
                                   : $signed({EW{1'b0}}))
                         + (move_y ? $signed({2'b00, delta_x_in})
                                   : $signed({EW{1'b0}}));
      end
   end

endmodule

// ===== hw/rtl/bresenham_line_stepper_unit.sv =====
// Top level of the Bresenham line stepper: handshakes, screen registers, result register.
`timescale 1ns / 1ps

// Integer Bresenham line stepper with screen clipping. A start item (func 0)
// loads two signed endpoints and returns the first pixel; each step item
// (func 1) returns the next one, flagged last when the line ends at its
// endpoint, leaves the screen (x at or beyond the screen width, or y at or
// beyond the screen height), or an axis would run past its target. Pixels
// with a negative coordinate come back with plotted low. A step with no
// line in progress returns (0,0), plotted low, last high. Throughput is one
// item per clock unless the result register stalls. The input register
// forms the deltas, signs and error term of a start item; one pass through
// the step logic between the line state and the result register does the
// clip, plot and advance and feeds the state back to itself, so its adds and
// compares set the clock rate. Users must write screen size through csr_bus
// only while no item is in flight (not enforced); csr_bus is always ready.
module bresenham_line_stepper_unit #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bls_req_if.sink   req_bus,
   bls_rsp_if.source rsp_bus,
   bls_csr_if.sink   csr_bus
);

   bls_pkg::stage_ctl_type ctl;

   logic signed [COORD_BITS-1:0] s_cur_x, s_cur_y, s_target_x, s_target_y;
   logic        [COORD_BITS:0]   s_delta_x;
   logic signed [COORD_BITS+1:0] s_neg_delta_y;
   logic                         s_step_x_neg, s_step_y_neg;
   logic signed [COORD_BITS+2:0] s_err_acc;

   logic signed [COORD_BITS-1:0] st_pixel_x, st_pixel_y;
   logic                         st_plotted, st_last;

   logic [bls_pkg::DIM_W-1:0] hres_ff, vres_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_BITS-1:0] pixel_x_ff, pixel_y_ff;
   logic                         plotted_ff, last_ff;

   logic out_free, advance, req_fire;

   // Result register takes a new item when empty or draining this cycle.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign advance  = ctl.valid && out_free;
   assign req_bus.ready = !ctl.valid || out_free;
   assign req_fire = req_bus.valid && req_bus.ready;

   // Screen size registers.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hres_ff <= bls_pkg::HRES_RST;
         vres_ff <= bls_pkg::VRES_RST;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            bls_pkg::CSR_HRES: begin
               hres_ff <= csr_bus.data;
            end
            bls_pkg::CSR_VRES: begin
               vres_ff <= csr_bus.data;
            end
            default: begin
            end
         endcase
      end
   end

   bls_setup #(
      .COORD_BITS (COORD_BITS)
   ) u_setup (
      .clock       (clock),
      .reset       (reset),
      .load        (req_fire),
      .advance     (advance),
      .func        (req_bus.func),
      .start_x     (req_bus.start_x),
      .start_y     (req_bus.start_y),
      .end_x       (req_bus.end_x),
      .end_y       (req_bus.end_y),
      .ctl         (ctl),
      .cur_x       (s_cur_x),
      .cur_y       (s_cur_y),
      .target_x    (s_target_x),
      .target_y    (s_target_y),
      .delta_x     (s_delta_x),
      .neg_delta_y (s_neg_delta_y),
      .step_x_neg  (s_step_x_neg),
      .step_y_neg  (s_step_y_neg),
      .err_acc     (s_err_acc)
   );

   bls_step #(
      .COORD_BITS (COORD_BITS)
   ) u_step (
      .clock          (clock),
      .reset          (reset),
      .fire           (advance),
      .ctl            (ctl),
      .ld_cur_x       (s_cur_x),
      .ld_cur_y       (s_cur_y),
      .ld_target_x    (s_target_x),
      .ld_target_y    (s_target_y),
      .ld_delta_x     (s_delta_x),
      .ld_neg_delta_y (s_neg_delta_y),
      .ld_step_x_neg  (s_step_x_neg),
      .ld_step_y_neg  (s_step_y_neg),
      .ld_err_acc     (s_err_acc),
      .hres           (hres_ff),
      .vres           (vres_ff),
      .pixel_x        (st_pixel_x),
      .pixel_y        (st_pixel_y),
      .plotted        (st_plotted),
      .last           (st_last)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_x_ff <= st_pixel_x;
         pixel_y_ff <= st_pixel_y;
         plotted_ff <= st_plotted;
         last_ff    <= st_last;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.pixel_x = pixel_x_ff;
   assign rsp_bus.pixel_y = pixel_y_ff;
   assign rsp_bus.plotted = plotted_ff;
   assign rsp_bus.last    = last_ff;

endmodule

// ===== hw/rtl/bls_checker.sv =====
// Port-level checks for the line stepper, bound to the top level.
`timescale 1ns / 1ps

module bls_checker #(
   parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   bls_req_if.sink   req_bus,
   bls_rsp_if.source rsp_bus,
   bls_csr_if.sink   csr_bus
);

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=>
         rsp_bus.valid && $stable(rsp_bus.pixel_x) && $stable(rsp_bus.pixel_y)
         && $stable(rsp_bus.plotted) && $stable(rsp_bus.last))
      else $error("bls: stalled result changed");

   // Drawn pixels never carry a negative coordinate.
   a_plot_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.plotted |->
         !rsp_bus.pixel_x[COORD_BITS-1] && !rsp_bus.pixel_y[COORD_BITS-1])
      else $error("bls: plotted pixel with negative coordinate");

   // A result appearing on an empty output follows a request transfer through the input and result registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(req_bus.valid && req_bus.ready, 2))
      else $error("bls: result without matching request");

   // Configuration port never stalls.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_bus.valid |-> csr_bus.ready)
      else $error("bls: configuration write stalled");

endmodule

bind bresenham_line_stepper_unit bls_checker #(
   .COORD_BITS (COORD_BITS)
) u_bls_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus),
   .csr_bus (csr_bus)
);

// ===== bench/testbench.sv =====
// Self-checking bench for the Bresenham line stepper: clipping, plotting and line ends.
`timescale 1ns / 1ps

module testbench;

   localparam int CW           = bls_pkg::COORD_BITS_DEF;
   localparam int ITEMS        = 1350;
   localparam int LIMIT_CYCLES = 200000;
   localparam int N_PHASES     = 6;

   // one request transfer as driven onto req_bus
   typedef struct {
      logic                 func;
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic signed [CW-1:0] ex;
      logic signed [CW-1:0] ey;
   } line_req_type;

   // one response transfer: the pixel of a step
   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic                 plotted;
      logic                 last;
   } pixel_type;

   // Scoreboard: walks its own copy of the line and keeps the pixels still owed.
   class pixel_scoreboard;
      logic [bls_pkg::DIM_W-1:0] scr_w, scr_h;
      logic signed [CW-1:0] cur_x, cur_y, tgt_x, tgt_y;
      logic [CW:0]          dx_abs;      // |dx|
      logic signed [CW+1:0] dy_neg;      // -|dy|
      logic signed [CW+2:0] err;
      bit                   sx_neg, sy_neg, drawing;
      pixel_type            pixel_q[$];
      int errors, n_checked, n_lines, n_steps, n_plotted, n_clipped, n_idle, n_dims;

      function new();
         scr_w   = bls_pkg::HRES_RST;
         scr_h   = bls_pkg::VRES_RST;
         cur_x   = '0;
         cur_y   = '0;
         tgt_x   = '0;
         tgt_y   = '0;
         dx_abs  = '0;
         dy_neg  = '0;
         err     = '0;
         sx_neg  = 1'b0;
         sy_neg  = 1'b0;
         drawing = 1'b0;
      endfunction

      function void set_dim(logic [bls_pkg::CSR_IDX_W-1:0] idx,
                            logic [bls_pkg::DIM_W-1:0] val);
         if (idx == bls_pkg::CSR_HRES)
            scr_w = val;
         else if (idx == bls_pkg::CSR_VRES)
            scr_h = val;
         n_dims++;
      endfunction

      function bit busy();
         return drawing;
      endfunction

      function int pending();
         return pixel_q.size();
      endfunction

      // one step of the line: clip, plot, then end or advance
      function pixel_type trace_step();
         pixel_type            r;
         logic signed [CW+3:0] e2;
         r.x       = cur_x;
         r.y       = cur_y;
         r.plotted = 1'b0;
         r.last    = 1'b1;
         if (!drawing) begin
            r.x = '0;
            r.y = '0;
            n_idle++;
            return r;
         end
         if (cur_x >= $signed({1'b0, scr_w}) || cur_y >= $signed({1'b0, scr_h})) begin
            drawing = 1'b0;
            n_clipped++;
            return r;
         end
         r.plotted = (cur_x >= 0) && (cur_y >= 0);
         if (cur_x == tgt_x && cur_y == tgt_y) begin
            drawing = 1'b0;
            return r;
         end
         e2 = {err, 1'b0};
         if (e2 >= dy_neg) begin
            // x axis already at target: line quits early
            if (cur_x == tgt_x) begin
               drawing = 1'b0;
               return r;
            end
            err   = err + dy_neg;
            cur_x = sx_neg ? cur_x - 16'sd1 : cur_x + 16'sd1;
         end
         if (e2 <= $signed({1'b0, dx_abs})) begin
            if (cur_y == tgt_y) begin
               drawing = 1'b0;
               return r;
            end
            err   = err + $signed({2'b00, dx_abs});
            cur_y = sy_neg ? cur_y - 16'sd1 : cur_y + 16'sd1;
         end
         r.last = 1'b0;
         return r;
      endfunction

      function void note_request(line_req_type it);
         logic signed [CW:0] dx, dy;
         pixel_type          p;
         if (it.func == bls_pkg::FUNC_START) begin
            cur_x   = it.sx;
            cur_y   = it.sy;
            tgt_x   = it.ex;
            tgt_y   = it.ey;
            dx      = tgt_x - cur_x;
            dy      = tgt_y - cur_y;
            dx_abs  = (dx < 0) ? -dx : dx;
            dy_neg  = (dy < 0) ? dy : -dy;
            sx_neg  = !(cur_x < tgt_x);
            sy_neg  = !(cur_y < tgt_y);
            err     = $signed({2'b00, dx_abs}) + dy_neg;
            drawing = 1'b1;
            n_lines++;
         end else begin
            n_steps++;
         end
         p = trace_step();
         if (p.plotted)
            n_plotted++;
         pixel_q.push_back(p);
      endfunction

      task report(string msg);
         if (errors < 40)
            $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_pixel(pixel_type got);
         pixel_type want;
         if (pixel_q.size() == 0) begin
            report($sformatf("pixel (%0d,%0d) with no transfer outstanding", got.x, got.y));
            return;
         end
         want = pixel_q.pop_front();
         n_checked++;
         if (got.x !== want.x)
            report($sformatf("pixel_x got %0d want %0d", got.x, want.x));
         if (got.y !== want.y)
            report($sformatf("pixel_y got %0d want %0d", got.y, want.y));
         if (got.plotted !== want.plotted)
            report($sformatf("plotted got %b want %b at (%0d,%0d)",
                             got.plotted, want.plotted, want.x, want.y));
         if (got.last !== want.last)
            report($sformatf("last got %b want %b at (%0d,%0d)",
                             got.last, want.last, want.x, want.y));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   bls_req_if req_bus ();
   bls_rsp_if rsp_bus ();
   bls_csr_if csr_bus ();

   bresenham_line_stepper_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   pixel_scoreboard sb = new();
   int        idle_pct = 24;   // shared by sender gaps and receiver stalls
   int        sent     = 0;
   pixel_type seen_px;

   always #2 clock = ~clock;

   // receiver: random stalls, changed on the falling edge
   initial rsp_bus.ready = 1'b0;
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
   end

   // response monitor: every transfer is checked against the oldest owed pixel
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_px.x       = rsp_bus.pixel_x;
         seen_px.y       = rsp_bus.pixel_y;
         seen_px.plotted = rsp_bus.plotted;
         seen_px.last    = rsp_bus.last;
         sb.check_pixel(seen_px);
      end
   end

   // watchdog
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("timeout after %0d cycles, %0d pixels still owed", LIMIT_CYCLES, sb.pending());
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic signed [CW-1:0] clip16(int v);
      if (v > 32767)
         return 16'sh7fff;
      if (v < -32768)
         return 16'sh8000;
      return v[CW-1:0];
   endfunction

   // drive one request; the scoreboard sees it at the edge it transfers
   task automatic send_item(line_req_type it);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.func    <= it.func;
      req_bus.start_x <= it.sx;
      req_bus.start_y <= it.sy;
      req_bus.end_x   <= it.ex;
      req_bus.end_y   <= it.ey;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(it);
      sent++;
   endtask

   // step item: endpoint fields are don't-care, so they carry noise
   task automatic send_step();
      line_req_type it;
      it.func = bls_pkg::FUNC_STEP;
      it.sx   = CW'($urandom);
      it.sy   = CW'($urandom);
      it.ex   = CW'($urandom);
      it.ey   = CW'($urandom);
      send_item(it);
   endtask

   // start a line, then step it until it ends or max_steps run out
   task automatic draw_line(int sx, int sy, int ex, int ey, int max_steps);
      line_req_type it;
      int           n;
      it.func = bls_pkg::FUNC_START;
      it.sx   = clip16(sx);
      it.sy   = clip16(sy);
      it.ex   = clip16(ex);
      it.ey   = clip16(ey);
      send_item(it);
      n = 0;
      while (sb.busy() && n < max_steps) begin
         send_step();
         n++;
      end
   endtask

   // drop valid and wait for every owed pixel
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [bls_pkg::CSR_IDX_W-1:0] idx,
                            logic [bls_pkg::DIM_W-1:0] val);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      sb.set_dim(idx, val);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // mostly short lines around the screen edges, some huge ones cut short,
   // some stray steps
   task automatic random_line();
      int kind, bx, by, w, h, cap;
      kind = $urandom_range(0, 19);
      w    = int'(sb.scr_w);
      h    = int'(sb.scr_h);
      if (kind == 0) begin
         send_step();
      end else if (kind <= 2) begin
         draw_line($signed(16'($urandom)), $signed(16'($urandom)),
                   $signed(16'($urandom)), $signed(16'($urandom)),
                   $urandom_range(0, 5));
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               bx = $urandom_range(0, 8) - 4;
               by = $urandom_range(0, 8) - 4;
            end
            1: begin
               bx = w - 4 + $urandom_range(0, 8);
               by = $urandom_range(0, h);
            end
            2: begin
               bx = $urandom_range(0, w);
               by = h - 4 + $urandom_range(0, 8);
            end
            default: begin
               bx = $urandom_range(0, w);
               by = $urandom_range(0, h);
            end
         endcase
         // now and then abandon the line with a new start
         cap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : 64;
         draw_line(bx, by, bx + $urandom_range(0, 32) - 16,
                   by + $urandom_range(0, 32) - 16, cap);
      end
   endtask

   initial begin
      int  phase_w[N_PHASES];
      int  phase_h[N_PHASES];
      int  stop_at, mid;
      bit  held;

      req_bus.valid   = 1'b0;
      req_bus.func    = bls_pkg::FUNC_START;
      req_bus.start_x = '0;
      req_bus.start_y = '0;
      req_bus.end_x   = '0;
      req_bus.end_y   = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = bls_pkg::CSR_HRES;
      csr_bus.data    = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed lines at reset screen size 1920 x 1080
      send_step();                                   // no line yet
      draw_line(0, 0, 0, 0, 50);                     // single point
      draw_line(2, 1, 5, 3, 50);                     // shallow, positive
      draw_line(3, -2, 0, 1, 50);                    // reversed, starts above screen
      draw_line(1918, 7, 1921, 7, 50);               // runs off the right edge
      draw_line(-32768, -32768, 32767, 32767, 1);    // extremes, cut short...
      draw_line(32767, -5, 0, 0, 50);                // ...by a start off screen
      draw_line(5, 1080, 5, 1070, 50);               // starts on the bottom edge
      draw_line(0, 0, 1, 4, 50);                     // steep
      send_step();                                   // after the line ended

      // screen settings per phase: extremes, zero, small, random, reset value
      phase_w = '{32767, 1, 0, 64, $urandom_range(0, 32767), 1920};
      phase_h = '{32767, 1, 0, 48, $urandom_range(0, 32767), 1080};
      held    = 1'b0;
      for (int p = 0; p < N_PHASES; p++) begin
         drain();
         csr_write(bls_pkg::CSR_HRES, bls_pkg::DIM_W'(phase_w[p]));
         csr_write(bls_pkg::CSR_VRES, bls_pkg::DIM_W'(phase_h[p]));
         idle_pct = (p == 3) ? 0 : 24;   // one long stretch with no gaps or stalls
         stop_at  = (p == N_PHASES - 1) ? ITEMS : sent + (ITEMS - sent) / (N_PHASES - p);
         mid      = sent + (stop_at - sent) / 2;
         while (sent < stop_at) begin
            random_line();
            // sender holds off once until the pipe runs dry
            if (p == 1 && !held && sent >= mid) begin
               drain();
               held = 1'b1;
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d pixels never arrived", sb.pending()));

      $display("%0d transfers over %0d screen writes: %0d lines, %0d steps, %0d idle steps",
               sent, sb.n_dims, sb.n_lines, sb.n_steps, sb.n_idle);
      $display("%0d pixels checked, %0d plotted, %0d lines clipped at the screen edge",
               sb.n_checked, sb.n_plotted, sb.n_clipped);
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
